/* rtl/dovc_pkg.sv */
// dovc_pkg: shared types, codes and helper functions of the difference order cost unit
package dovc_pkg;

   localparam int LEVELS     = 5;
   localparam int ORDERS     = 6;
   localparam int BINS       = 64;
   localparam int BIN_BITS   = 6;
   localparam int LVL_BITS   = 3;
   localparam int TOP_BITS   = 3;
   localparam int LEN_BITS   = 4;
   localparam int REQ_DATA_W = 80;

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_HIST   = 2'd1,
      MODE_MINMAX = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_COST   = 2'd0,
      KIND_HIST   = 2'd1,
      KIND_MINMAX = 2'd2
   } kind_type;

   // one transaction travelling down the difference chain
   typedef struct packed {
      logic                        valid;
      mode_type                    mode;
      logic                        last;
      logic [LVL_BITS-1:0]         lvl;
      logic [BIN_BITS-1:0]         bin;
      logic [TOP_BITS-1:0]         top;
      logic [ORDERS-1:0][63:0]     d;
   } item_type;

   // zigzag varint length, 1 to 10 bytes
   function automatic logic [LEN_BITS-1:0] zigzag_len(input logic [63:0] v);
      logic [63:0]         z;
      logic [LEN_BITS-1:0] n;
      z = {v[62:0], 1'b0} ^ {64{v[63]}};
      n = 4'd1;
      for (int k = 1; k < 10; k++) begin
         if ((z >> (7 * k)) != 64'd0) n = n + 4'd1;
      end
      return n;
   endfunction

   // redundant sign bits, wraps to 63 for zero and minus one
   function automatic logic [BIN_BITS-1:0] sign_bits(input logic [63:0] v);
      logic [63:0]         x;
      logic [BIN_BITS-1:0] pos;
      x   = v ^ {64{v[63]}};
      pos = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) pos = BIN_BITS'(i);
      end
      if (x == 64'd0) return 6'd63;
      return 6'd62 - pos;
   endfunction

endpackage

/* rtl/dovc_hist_ram.sv */
// dovc_hist_ram: one histogram row store, one write and one registered read port
module dovc_hist_ram #(
   parameter int WIDTH = 40
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [dovc_pkg::BIN_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]              wdata,
   input  logic [dovc_pkg::BIN_BITS-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   import dovc_pkg::*;

   logic [WIDTH-1:0] mem [BINS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/dovc_diff_chain.sv */
// dovc_diff_chain: systolic chain forming difference orders one stage per order
module dovc_diff_chain (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 accept,
   input  dovc_pkg::mode_type   mode,
   input  logic [63:0]          sample,
   input  logic                 last,
   input  logic [2:0]           level,
   input  logic [5:0]           bin,
   output dovc_pkg::item_type   tail
);
   import dovc_pkg::*;

   item_type                  st_ff [ORDERS];
   item_type                  st_in [ORDERS];
   logic [LEVELS-1:0][63:0]   prev_ff;
   logic [TOP_BITS-1:0]       seen_ff;
   logic [TOP_BITS-1:0]       seen_in;

   // samples of the current series, saturating at five
   always_comb begin
      seen_in = seen_ff;
      if (accept && mode == MODE_SAMPLE) begin
         if (last) seen_in = '0;
         else if (seen_ff < 3'd5) seen_in = seen_ff + 3'd1;
      end
   end

   always_comb begin
      st_in[0]       = '0;
      st_in[0].valid = accept;
      st_in[0].mode  = mode;
      st_in[0].last  = last;
      st_in[0].lvl   = level;
      st_in[0].bin   = bin;
      st_in[0].top   = seen_ff;
      st_in[0].d[0]  = sample;
      for (int j = 0; j < LEVELS; j++) begin
         st_in[j+1]        = st_ff[j];
         st_in[j+1].d[j+1] = st_ff[j].d[j] - prev_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         for (int j = 0; j < ORDERS; j++) st_ff[j].valid <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         if (advance) begin
            for (int j = 0; j < ORDERS; j++) st_ff[j] <= st_in[j];
         end
      end
   end

   // each order keeps the value its stage saw last
   always_ff @(posedge clock) begin
      for (int j = 0; j < LEVELS; j++) begin
         if (advance && st_ff[j].valid && st_ff[j].mode == MODE_SAMPLE &&
             st_ff[j].top >= TOP_BITS'(j))
            prev_ff[j] <= st_ff[j].d[j];
      end
   end

   assign tail = st_ff[ORDERS-1];

endmodule

/* rtl/difference_order_varint_cost_unit.sv */
// difference_order_varint_cost_unit: top level, commit stage, statistics and result register
//
// Streams signed 64-bit samples and estimates the zigzag varint byte cost of coding them
// raw and as differences of order 1 to 5. One transaction is taken per clock cycle while
// the result side keeps up and no clearing pass is running or pending; a transaction passes
// through the difference chain and the commit stage before its result (if any) appears in
// the output register, which the downstream side may stall. Each difference order from 1 to
// 5 has its own 64-entry histogram RAM of redundant sign bit counts; a same-bin update in
// consecutive cycles is forwarded. Min/max are registers. Reset starts a clearing pass over
// all 64 bins of the histogram RAMs during which no input transaction is accepted. A
// clear-statistics transaction holds off the input from its own acceptance until its
// clearing pass ends; that pass starts once the transaction reaches the commit stage.
module difference_order_varint_cost_unit #(
   parameter int COST_BITS       = 20,
   parameter int HIST_COUNT_BITS = 40,
   localparam int RSP_DATA_W     = ((6 * COST_BITS + 128 + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // sample[63:0], level[66:64], bin[72:67], zero fill
   input  logic [dovc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode[1:0]
   input  logic [1:0]                       req_tuser,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // cost_order0..cost_order5 (COST_BITS each), stat_low[63:0], stat_high[63:0], zero fill
   output logic [RSP_DATA_W-1:0]            rsp_tdata,
   // kind[1:0]
   output logic [1:0]                       rsp_tuser
);
   import dovc_pkg::*;

   localparam logic [COST_BITS-1:0]       CostMax = '1;
   localparam logic [HIST_COUNT_BITS-1:0] HistMax = '1;

   logic advance;
   logic accept;
   item_type tail;

   // commit stage
   item_type                                 sta_ff;
   logic [LEVELS-1:0][BIN_BITS-1:0]          addr_ff;
   logic [LEVELS-1:0][BIN_BITS-1:0]          addr_in;
   logic [ORDERS-1:0][LEN_BITS-1:0]          len_ff;
   logic [ORDERS-1:0][LEN_BITS-1:0]          len_in;

   // statistics and totals
   logic [LEVELS-1:0][63:0]                  min_ff, max_ff;
   logic [ORDERS-1:0][COST_BITS-1:0]         tot_ff;
   logic [ORDERS-1:0][COST_BITS-1:0]         tot_sum;

   // histogram ports and forwarding
   logic [LEVELS-1:0]                        we;
   logic [LEVELS-1:0][BIN_BITS-1:0]          waddr, raddr;
   logic [LEVELS-1:0][HIST_COUNT_BITS-1:0]   wdata, rdata, cur;
   logic [LEVELS-1:0]                        fwd_v_ff;
   logic [LEVELS-1:0][BIN_BITS-1:0]          fwd_a_ff;
   logic [LEVELS-1:0][HIST_COUNT_BITS-1:0]   fwd_d_ff;

   // clearing pass
   logic                  sweep_ff, pend_ff;
   logic [BIN_BITS-1:0]   cnt_ff;
   logic                  commit;

   // result register
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_kind_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic                    res_v;
   logic [1:0]              res_kind;
   logic [RSP_DATA_W-1:0]   res_data;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance && !sweep_ff && !pend_ff;
   assign accept     = req_tvalid && req_tready;
   assign commit     = advance && sta_ff.valid;

   dovc_diff_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .accept  (accept),
      .mode    (mode_type'(req_tuser)),
      .sample  (req_tdata[63:0]),
      .last    (req_tlast),
      .level   (req_tdata[66:64]),
      .bin     (req_tdata[72:67]),
      .tail    (tail)
   );

   // bins and lengths of the item leaving the chain
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         addr_in[l] = (tail.mode == MODE_SAMPLE) ? sign_bits(tail.d[l+1]) : tail.bin;
      end
      for (int k = 0; k < ORDERS; k++) begin
         len_in[k] = zigzag_len(tail.d[(TOP_BITS'(k) < tail.top) ? TOP_BITS'(k) : tail.top]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sta_ff.valid <= 1'b0;
      end else if (advance) begin
         sta_ff <= tail;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         addr_ff <= addr_in;
         len_ff  <= len_in;
      end
   end

   // a stalled commit stage reads its own bin again
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         raddr[l] = advance ? addr_in[l] : addr_ff[l];
         cur[l]   = (fwd_v_ff[l] && fwd_a_ff[l] == addr_ff[l]) ? fwd_d_ff[l] : rdata[l];
      end
   end

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         if (sweep_ff) begin
            we[l]    = 1'b1;
            waddr[l] = cnt_ff;
            wdata[l] = '0;
         end else begin
            we[l]    = commit && sta_ff.mode == MODE_SAMPLE &&
                       sta_ff.top >= TOP_BITS'(l + 1);
            waddr[l] = addr_ff[l];
            wdata[l] = (cur[l] == HistMax) ? cur[l] : cur[l] + HIST_COUNT_BITS'(1);
         end
      end
   end

   for (genvar g = 0; g < LEVELS; g++) begin : g_hist
      dovc_hist_ram #(.WIDTH(HIST_COUNT_BITS)) u_ram (
         .clock (clock),
         .we    (we[g]),
         .waddr (waddr[g]),
         .wdata (wdata[g]),
         .raddr (raddr[g]),
         .rdata (rdata[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_v_ff <= '0;
      end else begin
         for (int l = 0; l < LEVELS; l++) fwd_v_ff[l] <= we[l] && !sweep_ff;
      end
   end

   always_ff @(posedge clock) begin
      fwd_a_ff <= waddr;
      fwd_d_ff <= wdata;
   end

   // clearing pass after reset and after a clear transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= 1'b1;
         pend_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (accept && mode_type'(req_tuser) == MODE_CLEAR) pend_ff <= 1'b1;
         if (sweep_ff) begin
            cnt_ff <= cnt_ff + BIN_BITS'(1);
            if (cnt_ff == BIN_BITS'(BINS - 1)) sweep_ff <= 1'b0;
         end else if (commit && sta_ff.mode == MODE_CLEAR) begin
            sweep_ff <= 1'b1;
            pend_ff  <= 1'b0;
            cnt_ff   <= '0;
         end
      end
   end

   // saturating series totals
   always_comb begin
      for (int k = 0; k < ORDERS; k++) begin
         logic [COST_BITS:0] s;
         s = {1'b0, tot_ff[k]} + (COST_BITS + 1)'(len_ff[k]);
         tot_sum[k] = s[COST_BITS] ? CostMax : s[COST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ff <= '0;
         min_ff <= '0;
         max_ff <= '0;
      end else if (commit) begin
         case (sta_ff.mode)
            MODE_SAMPLE: begin
               tot_ff <= sta_ff.last ? '0 : tot_sum;
               for (int l = 0; l < LEVELS; l++) begin
                  if (sta_ff.top >= TOP_BITS'(l + 1)) begin
                     if ($signed(sta_ff.d[l+1]) < $signed(min_ff[l])) min_ff[l] <= sta_ff.d[l+1];
                     if ($signed(sta_ff.d[l+1]) > $signed(max_ff[l])) max_ff[l] <= sta_ff.d[l+1];
                  end
               end
            end
            MODE_CLEAR: begin
               min_ff <= '0;
               max_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // result of the committing transaction
   always_comb begin
      res_v    = 1'b0;
      res_kind = KIND_COST;
      res_data = '0;
      case (sta_ff.mode)
         MODE_SAMPLE: begin
            res_v = sta_ff.last;
            for (int k = 0; k < ORDERS; k++) res_data[k*COST_BITS +: COST_BITS] = tot_sum[k];
         end
         MODE_HIST: begin
            res_v    = 1'b1;
            res_kind = KIND_HIST;
            if (sta_ff.lvl < LVL_BITS'(LEVELS))
               res_data[6*COST_BITS +: 64] = 64'(cur[sta_ff.lvl]);
         end
         MODE_MINMAX: begin
            res_v    = 1'b1;
            res_kind = KIND_MINMAX;
            if (sta_ff.lvl < LVL_BITS'(LEVELS)) begin
               res_data[6*COST_BITS +: 64]      = min_ff[sta_ff.lvl];
               res_data[6*COST_BITS + 64 +: 64] = max_ff[sta_ff.lvl];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= commit && res_v;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_kind_ff <= res_kind;
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !req_tready) else $error("input taken during clearing pass");

   a_clear_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (commit && sta_ff.mode == MODE_CLEAR) |=> sweep_ff)
      else $error("clear did not start clearing pass");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (sweep_ff && cnt_ff == BIN_BITS'(BINS - 1)) |=> !sweep_ff)
      else $error("clearing pass overran");

   a_no_commit_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !(commit && sta_ff.mode == MODE_SAMPLE))
      else $error("sample committed during clearing pass");
`endif

endmodule
